FILE: sv/lba_pkg.sv
// Package for the linked block allocator: table geometry, entry codes,
// command and status codes, the table write word and the priority encoders.
// Depends on nothing; used by lba_table and linked_block_allocator.
package lba_pkg;

  localparam int NUM_BLOCKS = 256;
  localparam int BLK_W      = $clog2(NUM_BLOCKS);
  localparam int ENT_W      = $clog2(NUM_BLOCKS + 2);
  localparam int CNT_W      = 9;
  localparam int GRP_W      = 16;
  localparam int NUM_GRP    = NUM_BLOCKS / GRP_W;
  localparam int GIDX_W     = $clog2(NUM_GRP);
  localparam int BIDX_W     = $clog2(GRP_W);

  localparam logic [ENT_W-1:0] LINK_FREE = '0;
  localparam logic [ENT_W-1:0] LINK_END  = ENT_W'(NUM_BLOCKS + 1);

  localparam logic [2:0] CMD_ALLOC  = 3'd0;
  localparam logic [2:0] CMD_EXTEND = 3'd1;
  localparam logic [2:0] CMD_NEXT   = 3'd2;
  localparam logic [2:0] CMD_FREE   = 3'd3;
  localparam logic [2:0] CMD_LENGTH = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_END  = 2'd2;

  typedef struct packed {
    logic             en;
    logic [BLK_W-1:0] addr;
    logic [ENT_W-1:0] data;
  } tbl_wr_t;

  function automatic logic [BIDX_W-1:0] first_set(input logic [GRP_W-1:0] v);
    logic [BIDX_W-1:0] idx;
    idx = '0;
    for (int i = GRP_W - 1; i >= 0; i--) begin
      if (v[i]) idx = BIDX_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [GIDX_W-1:0] first_grp(input logic [NUM_GRP-1:0] v);
    logic [GIDX_W-1:0] idx;
    idx = '0;
    for (int i = NUM_GRP - 1; i >= 0; i--) begin
      if (v[i]) idx = GIDX_W'(i);
    end
    return idx;
  endfunction

endpackage

FILE: sv/lba_table.sv
// Link table storage: one synchronous memory of link entries plus a free
// bitmap in flops that reset sets, so a free entry reads as zero.
// Depends on lba_pkg.
module lba_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lba_pkg::tbl_wr_t              wr,
  input  logic [lba_pkg::BLK_W-1:0]     rd_addr,
  output logic [lba_pkg::ENT_W-1:0]     rd_entry,
  output logic [lba_pkg::NUM_BLOCKS-1:0] free_vec
);

  logic [lba_pkg::ENT_W-1:0]      mem [lba_pkg::NUM_BLOCKS];
  logic [lba_pkg::ENT_W-1:0]      rd_data_r;
  logic                           rd_free_r;
  logic [lba_pkg::NUM_BLOCKS-1:0] free_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r    <= '1;
      rd_free_r <= 1'b1;
    end else begin
      if (wr.en) begin
        free_r[wr.addr] <= (wr.data == lba_pkg::LINK_FREE);
      end
      rd_free_r <= free_r[rd_addr];
    end
  end

  assign rd_entry = rd_free_r ? lba_pkg::LINK_FREE : rd_data_r;
  assign free_vec = free_r;

endmodule

FILE: sv/linked_block_allocator.sv
// Linked block allocator top level: command sequencer over the link table.
// Depends on lba_pkg and lba_table.
//
// One command at a time: start is taken while busy is low, and the single
// result appears on the out_ ports for one cycle with out_valid; it cannot be
// stalled, so the receiver must take it then. Table reads use the synchronous
// link memory. Allocate does a free-group search, then a bit pick and write,
// stopping after the search when the table is full. Next fetches and checks
// the link; extend too, and with no link runs the allocate steps and then
// writes the link. Free and length walk the chain, fetching and checking
// each block, up to 256 blocks. The result shows in the cycle busy drops; an
// unused command answers in the next cycle without raising busy. The table
// starts all free right after reset with no clearing pass.
module linked_block_allocator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                in_cmd,
  input  logic [7:0]                in_block,
  output logic                      out_valid,
  output logic [7:0]                out_block_out,
  output logic [8:0]                out_chain_count,
  output logic [1:0]                out_status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_EVAL,
    S_GROUP,
    S_PICK,
    S_LINK
  } state_t;

  state_t                            state_r, state_nxt;
  logic [2:0]                        cmd_r, cmd_nxt;
  logic [lba_pkg::BLK_W-1:0]         blk_r, blk_nxt;
  logic [lba_pkg::BLK_W-1:0]         cur_r, cur_nxt;
  logic [lba_pkg::BLK_W-1:0]         nb_r, nb_nxt;
  logic [lba_pkg::GIDX_W-1:0]        grp_r, grp_nxt;
  logic                              skip_en_r, skip_en_nxt;
  logic [lba_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [lba_pkg::BLK_W-1:0]         out_block_r, out_block_nxt;
  logic [lba_pkg::CNT_W-1:0]         out_count_r, out_count_nxt;
  logic [1:0]                        out_status_r, out_status_nxt;

  lba_pkg::tbl_wr_t                  wr;
  logic [lba_pkg::ENT_W-1:0]         entry;
  logic [lba_pkg::NUM_BLOCKS-1:0]    free_vec;
  logic [lba_pkg::NUM_BLOCKS-1:0]    cand;
  logic [lba_pkg::NUM_GRP-1:0]       grp_any;
  logic [lba_pkg::GRP_W-1:0]         grp_bits;
  logic                              is_link;
  logic [lba_pkg::BLK_W-1:0]         link_blk;
  logic [lba_pkg::CNT_W-1:0]         count_inc;
  logic [lba_pkg::BLK_W-1:0]         pick_blk;

  lba_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .rd_addr  (cur_r),
    .rd_entry (entry),
    .free_vec (free_vec)
  );

  always_comb begin
    cand = free_vec;
    if (skip_en_r) begin
      cand[blk_r] = 1'b0;
    end
    for (int g = 0; g < lba_pkg::NUM_GRP; g++) begin
      grp_any[g] = |cand[g*lba_pkg::GRP_W +: lba_pkg::GRP_W];
    end
    grp_bits = cand[grp_r*lba_pkg::GRP_W +: lba_pkg::GRP_W];
  end

  assign is_link   = (entry != lba_pkg::LINK_FREE) &&
                     (entry <= lba_pkg::ENT_W'(lba_pkg::NUM_BLOCKS));
  assign link_blk  = lba_pkg::BLK_W'(entry - lba_pkg::ENT_W'(1));
  assign count_inc = count_r + lba_pkg::CNT_W'(1);
  assign pick_blk  = {grp_r, lba_pkg::first_set(grp_bits)};

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    blk_nxt        = blk_r;
    cur_nxt        = cur_r;
    nb_nxt         = nb_r;
    grp_nxt        = grp_r;
    skip_en_nxt    = skip_en_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_block_nxt  = out_block_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    wr             = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt     = in_cmd;
          blk_nxt     = in_block;
          cur_nxt     = in_block;
          skip_en_nxt = 1'b0;
          count_nxt   = (in_cmd == lba_pkg::CMD_LENGTH) ? lba_pkg::CNT_W'(1) : '0;
          case (in_cmd)
            lba_pkg::CMD_ALLOC: state_nxt = S_GROUP;
            lba_pkg::CMD_EXTEND,
            lba_pkg::CMD_NEXT,
            lba_pkg::CMD_FREE,
            lba_pkg::CMD_LENGTH: state_nxt = S_FETCH;
            default: begin
              out_valid_nxt  = 1'b1;
              out_block_nxt  = '0;
              out_count_nxt  = '0;
              out_status_nxt = lba_pkg::ST_OK;
            end
          endcase
        end
      end

      S_FETCH: state_nxt = S_EVAL;

      S_EVAL: begin
        out_block_nxt  = '0;
        out_count_nxt  = '0;
        out_status_nxt = lba_pkg::ST_OK;
        case (cmd_r)
          lba_pkg::CMD_EXTEND: begin
            if (is_link) begin
              out_valid_nxt = 1'b1;
              out_block_nxt = link_blk;
              state_nxt     = S_IDLE;
            end else begin
              skip_en_nxt = 1'b1;
              state_nxt   = S_GROUP;
            end
          end
          lba_pkg::CMD_NEXT: begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
            if (is_link) begin
              out_block_nxt = link_blk;
            end else begin
              out_status_nxt = lba_pkg::ST_END;
            end
          end
          lba_pkg::CMD_FREE: begin
            wr.en     = 1'b1;
            wr.addr   = cur_r;
            wr.data   = lba_pkg::LINK_FREE;
            count_nxt = count_inc;
            if (!is_link || count_inc >= lba_pkg::CNT_W'(lba_pkg::NUM_BLOCKS)) begin
              out_valid_nxt = 1'b1;
              out_count_nxt = count_inc;
              state_nxt     = S_IDLE;
            end else begin
              cur_nxt   = link_blk;
              state_nxt = S_FETCH;
            end
          end
          lba_pkg::CMD_LENGTH: begin
            if (!is_link || count_r >= lba_pkg::CNT_W'(lba_pkg::NUM_BLOCKS)) begin
              out_valid_nxt = 1'b1;
              out_count_nxt = count_r;
              state_nxt     = S_IDLE;
            end else begin
              cur_nxt   = link_blk;
              count_nxt = count_inc;
              state_nxt = S_FETCH;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        endcase
      end

      S_GROUP: begin
        if (grp_any == '0) begin
          out_valid_nxt  = 1'b1;
          out_block_nxt  = '0;
          out_count_nxt  = '0;
          out_status_nxt = lba_pkg::ST_FULL;
          state_nxt      = S_IDLE;
        end else begin
          grp_nxt   = lba_pkg::first_grp(grp_any);
          state_nxt = S_PICK;
        end
      end

      S_PICK: begin
        wr.en   = 1'b1;
        wr.addr = pick_blk;
        wr.data = lba_pkg::LINK_END;
        nb_nxt  = pick_blk;
        if (cmd_r == lba_pkg::CMD_EXTEND) begin
          state_nxt = S_LINK;
        end else begin
          out_valid_nxt  = 1'b1;
          out_block_nxt  = pick_blk;
          out_count_nxt  = '0;
          out_status_nxt = lba_pkg::ST_OK;
          state_nxt      = S_IDLE;
        end
      end

      S_LINK: begin
        wr.en          = 1'b1;
        wr.addr        = blk_r;
        wr.data        = lba_pkg::ENT_W'(nb_r) + lba_pkg::ENT_W'(1);
        out_valid_nxt  = 1'b1;
        out_block_nxt  = nb_r;
        out_count_nxt  = '0;
        out_status_nxt = lba_pkg::ST_OK;
        state_nxt      = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      skip_en_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      skip_en_r   <= skip_en_nxt;
    end
    cmd_r        <= cmd_nxt;
    blk_r        <= blk_nxt;
    cur_r        <= cur_nxt;
    nb_r         <= nb_nxt;
    grp_r        <= grp_nxt;
    count_r      <= count_nxt;
    out_block_r  <= out_block_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_block_out   = out_block_r;
  assign out_chain_count = out_count_r;
  assign out_status      = out_status_r;

endmodule

FILE: bench/tb_linked_block_allocator.sv
// Testbench for linked_block_allocator: directed, table-full, long-chain and random
// command tests, checked against a link-table predictor kept inside the bench.
// Depends on lba_pkg and the linked_block_allocator RTL.
module tb_linked_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
  localparam logic [2:0] CMD_UNUSED_MID = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;
  localparam int RANDOM_WORDS  = 80;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 2 * lba_pkg::NUM_BLOCKS + 20;

  typedef struct packed {
    logic [7:0] block_out;
    logic [8:0] chain_count;
    logic [1:0] status;
  } answer_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic [2:0] in_cmd = lba_pkg::CMD_ALLOC;
  logic [7:0] in_block = 8'd0;
  logic       busy;
  logic       out_valid;
  logic [7:0] out_block_out;
  logic [8:0] out_chain_count;
  logic [1:0] out_status;

  logic [lba_pkg::ENT_W-1:0] link_model [lba_pkg::NUM_BLOCKS];
  answer_t          pending_answers [$];
  int               mismatch_count = 0;
  int               stall_cycles = 0;
  bit               no_idle = 1'b0;
  logic [7:0]       chain_blk [lba_pkg::NUM_BLOCKS];

  linked_block_allocator u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_block        (in_block),
    .out_valid       (out_valid),
    .out_block_out   (out_block_out),
    .out_chain_count (out_chain_count),
    .out_status      (out_status)
  );

  always #2 clk = ~clk;

  function automatic bit is_link(logic [lba_pkg::ENT_W-1:0] e);
    return (e >= 1) && (e <= lba_pkg::NUM_BLOCKS);
  endfunction

  function automatic int lowest_free(int skip);
    for (int i = 0; i < lba_pkg::NUM_BLOCKS; i++) begin
      if (i != skip && link_model[i] == lba_pkg::LINK_FREE) return i;
    end
    return lba_pkg::NUM_BLOCKS;
  endfunction

  // Apply one command to the link table copy and return the answer it gives.
  function automatic answer_t table_step(logic [2:0] cmd, logic [7:0] blk);
    answer_t                   a;
    int                        nb;
    int                        cur;
    int                        cnt;
    logic [lba_pkg::ENT_W-1:0] e;
    a = '0;
    cnt = 0;
    case (cmd)
      lba_pkg::CMD_ALLOC: begin
        nb = lowest_free(lba_pkg::NUM_BLOCKS);
        if (nb >= lba_pkg::NUM_BLOCKS) begin
          a.status = lba_pkg::ST_FULL;
        end else begin
          link_model[nb] = lba_pkg::LINK_END;
          a.block_out = 8'(nb);
        end
      end
      lba_pkg::CMD_EXTEND: begin
        e = link_model[blk];
        if (is_link(e)) begin
          a.block_out = 8'(e - 1);
        end else begin
          nb = lowest_free(int'(blk));
          if (nb >= lba_pkg::NUM_BLOCKS) begin
            a.status = lba_pkg::ST_FULL;
          end else begin
            link_model[nb] = lba_pkg::LINK_END;
            link_model[blk] = lba_pkg::ENT_W'(nb + 1);
            a.block_out = 8'(nb);
          end
        end
      end
      lba_pkg::CMD_NEXT: begin
        e = link_model[blk];
        if (is_link(e)) a.block_out = 8'(e - 1);
        else a.status = lba_pkg::ST_END;
      end
      lba_pkg::CMD_FREE: begin
        cur = int'(blk);
        forever begin
          e = link_model[cur];
          link_model[cur] = lba_pkg::LINK_FREE;
          cnt++;
          if (!is_link(e) || cnt >= lba_pkg::NUM_BLOCKS) break;
          cur = int'(e) - 1;
        end
      end
      lba_pkg::CMD_LENGTH: begin
        cur = int'(blk);
        cnt = 1;
        forever begin
          e = link_model[cur];
          if (!is_link(e) || cnt >= lba_pkg::NUM_BLOCKS) break;
          cur = int'(e) - 1;
          cnt++;
        end
      end
      default: ;
    endcase
    a.chain_count = 9'(cnt);
    return a;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // Check each result word against the oldest pending answer.
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("word with nothing pending", out_block_out, 0);
      end else begin
        want = pending_answers.pop_front();
        if (out_block_out !== want.block_out)
          report_mismatch("block_out", out_block_out, want.block_out);
        if (out_chain_count !== want.chain_count)
          report_mismatch("chain_count", out_chain_count, want.chain_count);
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [2:0] cmd, input logic [7:0] blk, output answer_t ans);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_block <= blk;
    do @(posedge clk); while (busy !== 1'b0);
    ans = table_step(cmd, blk);
    pending_answers.push_back(ans);
  endtask

  task automatic drain_answers();
    start <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
  endtask

  task automatic test_directed();
    answer_t a;
    send_word(lba_pkg::CMD_ALLOC, 8'd0, a);
    send_word(lba_pkg::CMD_NEXT, 8'd0, a);
    send_word(lba_pkg::CMD_LENGTH, 8'd0, a);
    send_word(lba_pkg::CMD_EXTEND, 8'd0, a);
    send_word(lba_pkg::CMD_EXTEND, 8'd0, a);
    send_word(lba_pkg::CMD_EXTEND, 8'd1, a);
    send_word(lba_pkg::CMD_NEXT, 8'd0, a);
    send_word(lba_pkg::CMD_LENGTH, 8'd0, a);
    send_word(lba_pkg::CMD_NEXT, 8'd2, a);
    send_word(lba_pkg::CMD_NEXT, 8'd200, a);
    send_word(lba_pkg::CMD_LENGTH, 8'd255, a);
    send_word(lba_pkg::CMD_FREE, 8'd254, a);
    send_word(lba_pkg::CMD_EXTEND, 8'd255, a);
    send_word(lba_pkg::CMD_LENGTH, 8'd255, a);
    send_word(lba_pkg::CMD_NEXT, 8'd255, a);
    send_word(lba_pkg::CMD_FREE, 8'd1, a);
    send_word(lba_pkg::CMD_LENGTH, 8'd0, a);
    send_word(lba_pkg::CMD_EXTEND, 8'd0, a);
    send_word(lba_pkg::CMD_ALLOC, 8'd255, a);
    send_word(CMD_UNUSED_LO, 8'hFF, a);
    send_word(CMD_UNUSED_MID, 8'h00, a);
    send_word(CMD_UNUSED_HI, 8'h5A, a);
    send_word(lba_pkg::CMD_FREE, 8'd0, a);
    send_word(lba_pkg::CMD_FREE, 8'd255, a);
    drain_answers();
  endtask

  task automatic test_long_chain();
    answer_t a;
    int      n;
    send_word(lba_pkg::CMD_ALLOC, 8'd0, a);
    chain_blk[0] = a.block_out;
    n = 1;
    no_idle = 1'b1;
    while (n < lba_pkg::NUM_BLOCKS) begin
      send_word(lba_pkg::CMD_EXTEND, chain_blk[n-1], a);
      if (a.status != lba_pkg::ST_OK) break;
      chain_blk[n] = a.block_out;
      n++;
    end
    no_idle = 1'b0;
    send_word(lba_pkg::CMD_ALLOC, 8'd0, a);
    send_word(lba_pkg::CMD_EXTEND, chain_blk[n-1], a);
    send_word(lba_pkg::CMD_EXTEND, chain_blk[0], a);
    send_word(lba_pkg::CMD_LENGTH, chain_blk[0], a);
    send_word(lba_pkg::CMD_NEXT, chain_blk[n-1], a);
    send_word(lba_pkg::CMD_FREE, chain_blk[n/2], a);
    send_word(lba_pkg::CMD_LENGTH, chain_blk[0], a);
    send_word(lba_pkg::CMD_EXTEND, chain_blk[n/2 - 1], a);
    send_word(lba_pkg::CMD_EXTEND, chain_blk[(n*3)/4], a);
    send_word(lba_pkg::CMD_LENGTH, chain_blk[(n*3)/4], a);
    drain_answers();
  endtask

  // Fill what is left with one chain so a single free clears it again.
  task automatic test_full_table();
    answer_t    a;
    int         tries;
    logic [7:0] head;
    logic [7:0] tail;
    send_word(lba_pkg::CMD_ALLOC, 8'($urandom), a);
    head = a.block_out;
    tail = a.block_out;
    tries = 0;
    while (a.status == lba_pkg::ST_OK && tries < lba_pkg::NUM_BLOCKS) begin
      send_word(lba_pkg::CMD_EXTEND, tail, a);
      if (a.status == lba_pkg::ST_OK) tail = a.block_out;
      tries++;
    end
    send_word(lba_pkg::CMD_EXTEND, 8'd9, a);
    send_word(lba_pkg::CMD_FREE, 8'd77, a);
    send_word(lba_pkg::CMD_EXTEND, 8'd77, a);
    send_word(lba_pkg::CMD_ALLOC, 8'd0, a);
    send_word(lba_pkg::CMD_NEXT, 8'd77, a);
    drain_answers();
    send_word(lba_pkg::CMD_FREE, head, a);
    send_word(lba_pkg::CMD_FREE, chain_blk[0], a);
    send_word(lba_pkg::CMD_FREE, 8'd77, a);
    drain_answers();
  endtask

  // Mostly aim at blocks in use so chains get followed, grown and cut.
  function automatic logic [7:0] pick_block();
    int base;
    base = $urandom_range(0, lba_pkg::NUM_BLOCKS - 1);
    if ($urandom_range(0, 9) < 7) begin
      for (int i = 0; i < lba_pkg::NUM_BLOCKS; i++) begin
        if (link_model[(base + i) % lba_pkg::NUM_BLOCKS] != lba_pkg::LINK_FREE)
          return 8'((base + i) % lba_pkg::NUM_BLOCKS);
      end
    end
    return 8'(base);
  endfunction

  task automatic test_random();
    answer_t    a;
    int         r;
    logic [2:0] cmd;
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (k % 50 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 79) == 0) drain_answers();
      r = $urandom_range(0, 99);
      if (r < 25) cmd = lba_pkg::CMD_ALLOC;
      else if (r < 50) cmd = lba_pkg::CMD_EXTEND;
      else if (r < 65) cmd = lba_pkg::CMD_NEXT;
      else if (r < 80) cmd = lba_pkg::CMD_LENGTH;
      else if (r < 96) cmd = lba_pkg::CMD_FREE;
      else cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      send_word(cmd, pick_block(), a);
    end
    no_idle = 1'b0;
    drain_answers();
  endtask

  initial begin
    for (int i = 0; i < lba_pkg::NUM_BLOCKS; i++) link_model[i] = lba_pkg::LINK_FREE;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_long_chain();
    test_full_table();
    test_random();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_answers.size() != 0)
      report_mismatch("answers left pending", 0, pending_answers.size());
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
